// ===== hw/rtl/tcsbc_pkg.sv =====
package tcsbc_pkg;

    localparam int CELL_W = 40;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_MOVE  = 3'd2,
        OP_TICK  = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        REG_MODE    = 3'd0,
        REG_COLUMNS = 3'd1,
        REG_ROWS    = 3'd2,
        REG_PERIOD  = 3'd3,
        REG_BLINKD  = 3'd4
    } reg_idx_t;

    localparam logic [1:0] MODE_4BIT   = 2'd0;
    localparam logic [1:0] MODE_8BIT   = 2'd1;
    localparam logic [1:0] MODE_16BIT  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [7:0]  SPACE_CHAR = 8'h20;
    localparam logic [39:0] CELL_RESET = 40'h00_0007_20;

    // Datapath commands issued by the controller.
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_RD_CELL,
        CMD_WR_INPUT,
        CMD_WR_SWAP,
        CMD_WR_FILL
    } dp_cmd_t;

    // Address select for a datapath command.
    typedef enum logic [1:0] {
        ASEL_TARGET,
        ASEL_CURSOR,
        ASEL_SWEEP
    } asel_t;

    typedef struct packed {
        dp_cmd_t cmd;
        asel_t   asel;
    } dp_ctrl_t;

    function automatic logic [39:0] pack_cell(input logic [1:0] mode, input logic [7:0] ch,
                                              input logic [15:0] bg, input logic [15:0] fg);
        logic [15:0] a;
        logic [15:0] b;
        a = 16'd0;
        b = 16'd0;
        case (mode)
            MODE_4BIT: begin
                a = {8'd0, bg[3:0], 4'd0} | {8'd0, fg[7:0]};
            end
            MODE_8BIT: begin
                a = {8'd0, fg[7:0]};
                b = {8'd0, bg[7:0]};
            end
            default: begin
                a = fg;
                b = bg;
            end
        endcase
        return {b, a, ch};
    endfunction

    // Unpacked fields: {ch, bg, fg}.
    function automatic logic [39:0] unpack_cell(input logic [1:0] mode, input logic [39:0] w);
        logic [15:0] a;
        logic [15:0] b;
        logic [39:0] res;
        a = w[23:8];
        b = w[39:24];
        case (mode)
            MODE_4BIT:  res = {w[7:0], 12'd0, a[7:4], 12'd0, a[3:0]};
            MODE_8BIT:  res = {w[7:0], 8'd0, b[7:0], 8'd0, a[7:0]};
            MODE_16BIT: res = {w[7:0], b, a};
            default:    res = 40'd0;
        endcase
        return res;
    endfunction

endpackage

// ===== hw/rtl/tcsbc_ram.sv =====
module tcsbc_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/tcsbc_datapath.sv =====
module tcsbc_datapath #(
    parameter int MAX_COLUMNS = 80,
    parameter int CELL_DEPTH  = 8192
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tcsbc_pkg::dp_ctrl_t               ctrl,
    input  logic [1:0]                        color_mode,
    input  logic [6:0]                        columns,
    input  logic [5:0]                        target_row,
    input  logic [6:0]                        target_col,
    input  logic [5:0]                        cursor_row,
    input  logic [6:0]                        cursor_col,
    input  logic [7:0]                        in_char,
    input  logic [15:0]                       in_back,
    input  logic [15:0]                       in_fore,
    input  logic [15:0]                       fill_back,
    input  logic [15:0]                       fill_fore,
    input  logic                              sweep_start,
    input  logic [$clog2(CELL_DEPTH+1)-1:0]   sweep_total,
    output logic                              sweep_last,
    output logic                              init_done,
    output logic [39:0]                       rd_fields
);
    import tcsbc_pkg::*;

    localparam int AW = $clog2(CELL_DEPTH);
    localparam int CW = $clog2(CELL_DEPTH + 1);

    logic [12:0]   tgt_lin;
    logic [12:0]   cur_lin;
    logic [AW-1:0] addr;
    logic [CW-1:0] sweep_reg, sweep_next;
    logic [6:0]    sweep_col_reg, sweep_col_next;
    logic [CW-1:0] init_reg;
    logic          init_done_reg;
    logic [39:0]   rdata;
    logic [39:0]   cell_u;
    logic          we;
    logic [39:0]   wdata;

    assign tgt_lin = 13'(target_row) * 13'(columns) + 13'(target_col);
    assign cur_lin = 13'(cursor_row) * 13'(columns) + 13'(cursor_col);

    always_comb begin
        case (ctrl.asel)
            ASEL_TARGET: addr = AW'(tgt_lin);
            ASEL_CURSOR: addr = AW'(cur_lin);
            default:     addr = sweep_reg[AW-1:0];
        endcase
    end

    // Reset clearing pass runs first, then the commanded accesses.
    assign cell_u = unpack_cell(color_mode, rdata);
    always_comb begin
        we    = 1'b0;
        wdata = pack_cell(color_mode, in_char, in_back, in_fore);
        if (!init_done_reg) begin
            we    = 1'b1;
            wdata = CELL_RESET;
        end else begin
            case (ctrl.cmd)
                CMD_WR_INPUT: we = (color_mode != MODE_UNUSED);
                CMD_WR_SWAP: begin
                    we    = (color_mode != MODE_UNUSED);
                    wdata = pack_cell(color_mode, cell_u[39:32], cell_u[15:0], cell_u[31:16]);
                end
                CMD_WR_FILL: begin
                    // Columns beyond the widest supported row are skipped.
                    we    = (color_mode != MODE_UNUSED) && (32'(sweep_col_reg) < MAX_COLUMNS);
                    wdata = pack_cell(color_mode, SPACE_CHAR, fill_back, fill_fore);
                end
                default: we = 1'b0;
            endcase
        end
    end

    tcsbc_ram #(.WIDTH(CELL_W), .DEPTH(CELL_DEPTH)) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(init_done_reg ? addr : init_reg[AW-1:0]),
        .wdata(wdata),
        .raddr(addr),
        .rdata(rdata)
    );

    always_comb begin
        sweep_next     = sweep_reg;
        sweep_col_next = sweep_col_reg;
        if (sweep_start) begin
            sweep_next     = '0;
            sweep_col_next = 7'd0;
        end else if (ctrl.cmd == CMD_WR_FILL) begin
            sweep_next     = sweep_reg + CW'(1);
            sweep_col_next = (sweep_col_reg == columns - 7'd1) ? 7'd0 : sweep_col_reg + 7'd1;
        end
    end
    assign sweep_last = (sweep_reg + CW'(1) >= sweep_total);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg      <= '0;
            init_done_reg <= 1'b0;
            sweep_reg     <= '0;
            sweep_col_reg <= 7'd0;
        end else begin
            sweep_reg     <= sweep_next;
            sweep_col_reg <= sweep_col_next;
            if (!init_done_reg) begin
                init_reg <= init_reg + CW'(1);
                if (init_reg == CW'(CELL_DEPTH - 1)) begin
                    init_done_reg <= 1'b1;
                end
            end
        end
    end

    assign init_done = init_done_reg;
    assign rd_fields = cell_u;
endmodule

// ===== hw/rtl/tcsbc_ctrl.sv =====
module tcsbc_ctrl #(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_ROWS    = 60,
    parameter int CELL_DEPTH  = 8192
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            init_done,
    input  logic                            in_fire,
    input  logic [2:0]                      op,
    input  logic [5:0]                      row,
    input  logic [6:0]                      col,
    input  logic [15:0]                     back_in,
    input  logic [15:0]                     fore_in,
    input  logic [1:0]                      color_mode,
    input  logic [6:0]                      columns,
    input  logic [5:0]                      rows,
    input  logic [15:0]                     blink_period,
    input  logic                            blink_disable,
    input  logic                            sweep_last,
    input  logic [39:0]                     rd_fields,
    input  logic                            out_ready,
    output logic                            in_ready,
    output logic                            out_valid,
    output logic [41:0]                     out_data,
    output tcsbc_pkg::dp_ctrl_t             ctrl,
    output logic [5:0]                      cursor_row,
    output logic [6:0]                      cursor_col,
    output logic [15:0]                     fill_back,
    output logic [15:0]                     fill_fore,
    output logic                            sweep_start,
    output logic [$clog2(CELL_DEPTH+1)-1:0] sweep_total
);
    import tcsbc_pkg::*;

    localparam int CW = $clog2(CELL_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_READ_WAIT, S_READ_DONE, S_OLD_RD, S_OLD_WAIT, S_OLD_WR,
        S_NEW_RD, S_NEW_WAIT, S_NEW_WR, S_SWEEP, S_OUT
    } state_t;

    state_t      state_reg;
    logic [2:0]  op_reg;
    logic [5:0]  cur_row_reg;
    logic [6:0]  cur_col_reg;
    logic        cur_on_reg;
    logic [15:0] timer_reg;
    logic [15:0] fb_reg, ff_reg;
    logic [39:0] res_reg;
    logic        rej_reg;
    logic        out_valid_reg;
    logic [41:0] out_data_reg;
    logic        tgt_ok, cur_ok, same;
    logic [12:0] tgt_lin, cur_lin;
    logic [15:0] timer_inc;
    logic [15:0] lim;
    logic        lim_any;
    logic [5:0]  rows_eff;
    logic [12:0] area;

    assign tgt_lin = 13'(row) * 13'(columns) + 13'(col);
    assign cur_lin = 13'(cur_row_reg) * 13'(columns) + 13'(cur_col_reg);
    assign tgt_ok = (row < rows) && (col < columns) && (32'(row) < MAX_ROWS)
                    && (32'(col) < MAX_COLUMNS) && (32'(tgt_lin) < CELL_DEPTH);
    assign cur_ok = (cur_row_reg < rows) && (cur_col_reg < columns)
                    && (32'(cur_row_reg) < MAX_ROWS) && (32'(cur_col_reg) < MAX_COLUMNS)
                    && (32'(cur_lin) < CELL_DEPTH);
    assign same = (row == cur_row_reg) && (col == cur_col_reg);
    assign timer_inc = timer_reg + 16'd1;

    always_comb begin
        lim_any = 1'b1;
        case (color_mode)
            MODE_4BIT:  lim = 16'd15;
            MODE_8BIT:  lim = 16'd255;
            MODE_16BIT: lim = 16'hFFFF;
            default: begin
                lim     = 16'd0;
                lim_any = 1'b0;
            end
        endcase
    end

    always_comb begin
        ctrl.cmd  = CMD_NONE;
        ctrl.asel = ASEL_TARGET;
        case (state_reg)
            S_DISPATCH: begin
                if (op_reg == OP_WRITE && tgt_ok) begin
                    ctrl.cmd = CMD_WR_INPUT;
                end else if (op_reg == OP_READ) begin
                    ctrl.cmd = CMD_RD_CELL;
                end
            end
            S_OLD_RD: begin
                ctrl.asel = ASEL_CURSOR;
                ctrl.cmd  = CMD_RD_CELL;
            end
            S_OLD_WAIT: ctrl.asel = ASEL_CURSOR;
            S_OLD_WR: begin
                ctrl.asel = ASEL_CURSOR;
                ctrl.cmd  = CMD_WR_SWAP;
            end
            S_NEW_RD: begin
                ctrl.asel = ASEL_CURSOR;
                ctrl.cmd  = CMD_RD_CELL;
            end
            S_NEW_WAIT: ctrl.asel = ASEL_CURSOR;
            S_NEW_WR: begin
                ctrl.asel = ASEL_CURSOR;
                ctrl.cmd  = CMD_WR_SWAP;
            end
            S_SWEEP: begin
                ctrl.asel = ASEL_SWEEP;
                ctrl.cmd  = CMD_WR_FILL;
            end
            default: ctrl.cmd = CMD_NONE;
        endcase
    end

    // The clear walks the rows that exist in the store, each row linearly; the
    // datapath skips columns beyond the widest supported row.
    assign sweep_start = (state_reg == S_DISPATCH);
    assign rows_eff    = (32'(rows) > MAX_ROWS) ? 6'(MAX_ROWS) : rows;
    assign area        = 13'(rows_eff) * 13'(columns);
    assign sweep_total = (32'(area) > CELL_DEPTH) ? CW'(CELL_DEPTH) : CW'(area);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cur_row_reg   <= 6'd15;
            cur_col_reg   <= 7'd40;
            cur_on_reg    <= 1'b0;
            timer_reg     <= 16'd0;
            fb_reg        <= 16'd0;
            ff_reg        <= 16'd7;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_WRITE;
        end else begin
            // The output register takes a finished result once its slot is free.
            if (state_reg == S_OUT && (!out_valid_reg || out_ready)) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {rej_reg, cur_on_reg, res_reg[15:0], res_reg[31:16],
                                  res_reg[39:32]};
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        op_reg  <= op;
                        res_reg <= '0;
                        rej_reg <= 1'b0;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    case (op_reg)
                        OP_WRITE: begin
                            rej_reg   <= !tgt_ok;
                            state_reg <= S_OUT;
                        end
                        OP_READ: begin
                            rej_reg   <= !tgt_ok;
                            state_reg <= tgt_ok ? S_READ_WAIT : S_OUT;
                        end
                        OP_MOVE: begin
                            if (!tgt_ok) begin
                                rej_reg   <= 1'b1;
                                state_reg <= S_OUT;
                            end else if (!same) begin
                                cur_on_reg <= 1'b1;
                                // The old cell is restored first, so the old position
                                // is kept until its write is done.
                                if (cur_on_reg && cur_ok) begin
                                    state_reg <= S_OLD_RD;
                                end else begin
                                    cur_row_reg <= row;
                                    cur_col_reg <= col;
                                    state_reg   <= S_NEW_RD;
                                end
                            end else if (!cur_ok) begin
                                rej_reg   <= 1'b1;
                                state_reg <= S_OUT;
                            end else if (cur_on_reg || !blink_disable) begin
                                cur_on_reg <= !cur_on_reg;
                                state_reg  <= S_NEW_RD;
                            end else begin
                                state_reg <= S_OUT;
                            end
                        end
                        OP_TICK: begin
                            if (timer_inc > blink_period) begin
                                timer_reg <= 16'd0;
                                if (!cur_ok) begin
                                    rej_reg   <= 1'b1;
                                    state_reg <= S_OUT;
                                end else if (cur_on_reg || !blink_disable) begin
                                    cur_on_reg <= !cur_on_reg;
                                    state_reg  <= S_NEW_RD;
                                end else begin
                                    state_reg <= S_OUT;
                                end
                            end else begin
                                timer_reg <= timer_inc;
                                state_reg <= S_OUT;
                            end
                        end
                        OP_CLEAR: begin
                            if (back_in != fore_in && lim_any) begin
                                if (back_in <= lim) fb_reg <= back_in;
                                if (fore_in <= lim) ff_reg <= fore_in;
                            end
                            state_reg <= (rows != 6'd0 && columns != 7'd0) ? S_SWEEP : S_OUT;
                        end
                        default: state_reg <= S_OUT;
                    endcase
                end
                S_READ_WAIT: state_reg <= S_READ_DONE;
                S_READ_DONE: begin
                    res_reg   <= rd_fields;
                    state_reg <= S_OUT;
                end
                S_OLD_RD:   state_reg <= S_OLD_WAIT;
                S_OLD_WAIT: state_reg <= S_OLD_WR;
                S_OLD_WR: begin
                    cur_row_reg <= row;
                    cur_col_reg <= col;
                    state_reg   <= S_NEW_RD;
                end
                S_NEW_RD:   state_reg <= S_NEW_WAIT;
                S_NEW_WAIT: state_reg <= S_NEW_WR;
                S_NEW_WR:   state_reg <= S_OUT;
                S_SWEEP: begin
                    if (sweep_last) state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!out_valid_reg || out_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready   = (state_reg == S_IDLE) && init_done;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign cursor_row = cur_row_reg;
    assign cursor_col = cur_col_reg;
    assign fill_back  = fb_reg;
    assign fill_fore  = ff_reg;
endmodule

// ===== hw/rtl/text_cell_store_with_blinking_cursor.sv =====
// A clear walks min(rows, MAX_ROWS)*columns cells (at most CELL_DEPTH), one cell per
// cycle through the single write port of the cell memory. A result is offered in the
// same cycle as the next item can be taken; one item is in flight.
// Reset (aresetn low, synchronous) restores registers and cursor state, then a clearing
// pass fills all CELL_DEPTH cells of the memory; no input transfer is taken until it ends.
module text_cell_store_with_blinking_cursor #(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_ROWS    = 60,
    parameter int CELL_DEPTH  = 8192
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], row[8:3], col[15:9], character[23:16], back_color[39:24],
    // fore_color[55:40]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_character[7:0], read_back[23:8], read_fore[39:24], cursor_shown[40],
    // rejected[41], zero fill above
    output logic [47:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tcsbc_pkg::*;

    localparam int CW = $clog2(CELL_DEPTH + 1);

    logic [1:0]  mode_reg;
    logic [6:0]  columns_reg;
    logic [5:0]  rows_reg;
    logic [15:0] period_reg;
    logic        blinkd_reg;

    // Configuration registers take a write in any cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= 2'd0;
            columns_reg <= 7'd80;
            rows_reg    <= 6'd30;
            period_reg  <= 16'd15;
            blinkd_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MODE:    mode_reg    <= cfg_data[1:0];
                REG_COLUMNS: columns_reg <= cfg_data[6:0];
                REG_ROWS:    rows_reg    <= cfg_data[5:0];
                REG_PERIOD:  period_reg  <= cfg_data;
                REG_BLINKD:  blinkd_reg  <= cfg_data[0];
                default:     mode_reg    <= mode_reg;
            endcase
        end
    end

    logic [55:0] in_reg;
    logic        in_fire;
    dp_ctrl_t    ctrl;
    logic [5:0]  cur_row;
    logic [6:0]  cur_col;
    logic [15:0] fill_back, fill_fore;
    logic        sweep_start, sweep_last, init_done;
    logic [CW-1:0] sweep_total;
    logic [39:0] rd_fields;
    logic [41:0] out_data;

    assign in_fire = s_tvalid && s_tready;

    // The accepted transfer is held for the whole operation.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_reg <= s_tdata;
        end
    end

    tcsbc_ctrl #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS), .CELL_DEPTH(CELL_DEPTH)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .init_done    (init_done),
        .in_fire      (in_fire),
        .op           (s_tdata[2:0]),
        .row          (in_reg[8:3]),
        .col          (in_reg[15:9]),
        .back_in      (in_reg[39:24]),
        .fore_in      (in_reg[55:40]),
        .color_mode   (mode_reg),
        .columns      (columns_reg),
        .rows         (rows_reg),
        .blink_period (period_reg),
        .blink_disable(blinkd_reg),
        .sweep_last   (sweep_last),
        .rd_fields    (rd_fields),
        .out_ready    (m_tready),
        .in_ready     (s_tready),
        .out_valid    (m_tvalid),
        .out_data     (out_data),
        .ctrl         (ctrl),
        .cursor_row   (cur_row),
        .cursor_col   (cur_col),
        .fill_back    (fill_back),
        .fill_fore    (fill_fore),
        .sweep_start  (sweep_start),
        .sweep_total  (sweep_total)
    );

    tcsbc_datapath #(.MAX_COLUMNS(MAX_COLUMNS), .CELL_DEPTH(CELL_DEPTH))
    u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .color_mode (mode_reg),
        .columns    (columns_reg),
        .target_row (in_reg[8:3]),
        .target_col (in_reg[15:9]),
        .cursor_row (cur_row),
        .cursor_col (cur_col),
        .in_char    (in_reg[23:16]),
        .in_back    (in_reg[39:24]),
        .in_fore    (in_reg[55:40]),
        .fill_back  (fill_back),
        .fill_fore  (fill_fore),
        .sweep_start(sweep_start),
        .sweep_total(sweep_total),
        .sweep_last (sweep_last),
        .init_done  (init_done),
        .rd_fields  (rd_fields)
    );

    assign m_tdata = {6'd0, out_data};

    // No input transfer is taken during the clearing pass after reset.
    a_no_accept_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !s_tready) else $error("input taken during clearing pass");

    // A result stays offered until it is taken.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");

    // The block never takes a new item while the last one is still being worked on.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready) else $error("second item accepted");
endmodule
